FILE: design/qfa_pkg.sv
package qfa_pkg;

  typedef enum logic [2:0] {
    OP_ADD = 3'd0,
    OP_SUB = 3'd1,
    OP_MUL = 3'd2,
    OP_DIV = 3'd3,
    OP_INC = 3'd4,
    OP_DEC = 3'd5,
    OP_MIN = 3'd6,
    OP_MAX = 3'd7
  } op_t;

  localparam logic [31:0] WORD_MAX = 32'h7fff_ffff;
  localparam logic [31:0] WORD_MIN = 32'h8000_0000;

  typedef struct packed {
    logic [2:0]         req_type;
    logic signed [31:0] operand_a;
    logic signed [31:0] operand_b;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] result_value;
    logic               a_less;
    logic               a_equal;
    logic               a_greater;
    logic               overflow;
    logic               divide_by_zero;
  } out_item_t;

  // Context that rides along the divider chain with each item.
  typedef struct packed {
    op_t         op;
    logic [31:0] fast_res;
    logic        fast_ovf;
    logic        a_less;
    logic        a_equal;
    logic        a_greater;
    logic        neg;
    logic        dz;
    logic [31:0] d;
    logic [63:0] prod;
  } ctx_t;

endpackage

FILE: design/qfa_front.sv
module qfa_front import qfa_pkg::*; #(
  parameter int FRAC_BITS = 8,
  parameter int NW = 32 + FRAC_BITS
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          en,
  input  logic          in_valid,
  input  in_item_t      in_data,
  output logic          valid_r,
  output ctx_t          ctx_r,
  output logic [NW-1:0] word_r
);

  logic signed [31:0] a, b;
  logic [32:0] s;
  logic [31:0] ma, mb;
  ctx_t        ctx_nxt;
  op_t         op;

  assign a  = in_data.operand_a;
  assign b  = in_data.operand_b;
  assign op = op_t'(in_data.req_type);
  assign ma = a[31] ? 32'(-a) : a;
  assign mb = b[31] ? 32'(-b) : b;

  always_comb begin
    case (op)
      OP_SUB:  s = {a[31], a} - {b[31], b};
      OP_INC:  s = {a[31], a} + 33'd1;
      OP_DEC:  s = {a[31], a} - 33'd1;
      default: s = {a[31], a} + {b[31], b};
    endcase
    ctx_nxt           = '0;
    ctx_nxt.op        = op;
    ctx_nxt.a_less    = a < b;
    ctx_nxt.a_equal   = a == b;
    ctx_nxt.a_greater = a > b;
    ctx_nxt.neg       = a[31] ^ b[31];
    ctx_nxt.dz        = (b == 32'sd0);
    ctx_nxt.d         = mb;
    ctx_nxt.prod      = 64'(ma) * 64'(mb);
    if (s[32] != s[31]) begin
      ctx_nxt.fast_ovf = 1'b1;
      ctx_nxt.fast_res = s[32] ? WORD_MIN : WORD_MAX;
    end else begin
      ctx_nxt.fast_res = s[31:0];
    end
    if (op == OP_MIN) begin
      ctx_nxt.fast_ovf = 1'b0;
      ctx_nxt.fast_res = (a < b) ? a : b;
    end else if (op == OP_MAX) begin
      ctx_nxt.fast_ovf = 1'b0;
      ctx_nxt.fast_res = (a > b) ? a : b;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= in_valid;
    end
    if (en) begin
      ctx_r  <= ctx_nxt;
      word_r <= {ma, {FRAC_BITS{1'b0}}};
    end
  end

endmodule

FILE: design/qfa_cell.sv
module qfa_cell import qfa_pkg::*; #(
  parameter int NW = 40
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          en,
  input  logic          in_valid,
  input  ctx_t          in_ctx,
  input  logic [31:0]   in_rem,
  input  logic [NW-1:0] in_word,
  output logic          valid_r,
  output ctx_t          ctx_r,
  output logic [31:0]   rem_r,
  output logic [NW-1:0] word_r
);

  logic [32:0] t, diff;
  logic        ge;

  // One restoring step: bring down the next numerator bit, try the subtract.
  assign t    = {in_rem, in_word[NW-1]};
  assign ge   = t >= {1'b0, in_ctx.d};
  assign diff = t - {1'b0, in_ctx.d};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= in_valid;
    end
    if (en) begin
      ctx_r  <= in_ctx;
      rem_r  <= ge ? diff[31:0] : t[31:0];
      word_r <= {in_word[NW-2:0], ge};
    end
  end

endmodule

FILE: design/qfa_finish.sv
module qfa_finish import qfa_pkg::*; #(
  parameter int FRAC_BITS = 8,
  parameter int NW = 32 + FRAC_BITS
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          en,
  input  logic          in_valid,
  input  ctx_t          in_ctx,
  input  logic [31:0]   in_rem,
  input  logic [NW-1:0] in_word,
  output logic          valid_r,
  output out_item_t     data_r
);

  logic        up;
  logic [63:0] m, op_x, op_y, sum;
  logic        big;
  out_item_t   data_nxt;

  assign up = {in_rem, 1'b0} >= {1'b0, in_ctx.d};

  always_comb begin
    if (in_ctx.op == OP_MUL) begin
      op_x = in_ctx.prod;
      op_y = 64'(1) << (FRAC_BITS - 1);
    end else begin
      op_x = 64'(in_word);
      op_y = 64'(up);
    end
    sum = op_x + op_y;
    m   = (in_ctx.op == OP_MUL) ? (sum >> FRAC_BITS) : sum;
    big = in_ctx.neg ? (m > 64'h8000_0000) : (m > 64'h7fff_ffff);

    data_nxt                = '0;
    data_nxt.a_less         = in_ctx.a_less;
    data_nxt.a_equal        = in_ctx.a_equal;
    data_nxt.a_greater      = in_ctx.a_greater;
    data_nxt.result_value   = in_ctx.fast_res;
    data_nxt.overflow       = in_ctx.fast_ovf;
    if (in_ctx.op == OP_MUL || in_ctx.op == OP_DIV) begin
      data_nxt.overflow = big;
      if (big) begin
        data_nxt.result_value = in_ctx.neg ? WORD_MIN : WORD_MAX;
      end else begin
        data_nxt.result_value = in_ctx.neg ? 32'(-m[31:0]) : m[31:0];
      end
    end
    if (in_ctx.op == OP_DIV && in_ctx.dz) begin
      data_nxt.result_value   = '0;
      data_nxt.overflow       = 1'b0;
      data_nxt.divide_by_zero = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= in_valid;
    end
    if (en) begin
      data_r <= data_nxt;
    end
  end

endmodule

FILE: design/q24_8_fixed_point_alu_core.sv
// Signed fixed-point ALU (Q24.8 at FRAC_BITS = 8): add, sub, mul, div, inc,
// dec, min and max on raw 32-bit operands, with saturation, overflow,
// divide-by-zero and compare flags. One item enters per cycle while in_stall
// is low. Each item passes a front stage (decode, add and multiply), the
// divider chain of one quotient bit per cell and a finish stage (rounding
// and saturation). Every item walks the whole chain, so results leave in
// order. Stages collapse bubbles, so a stalled result does not stop input
// until the chain is full.
module q24_8_fixed_point_alu_core import qfa_pkg::*; #(
  parameter int FRAC_BITS = 8
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  localparam int NW = 32 + FRAC_BITS;

  // stage 0 is the front; stages 1..NW are divider cells
  logic          v    [NW+1];
  ctx_t          ctx  [NW+1];
  logic [31:0]   rem  [NW+1];
  logic [NW-1:0] word [NW+1];
  logic          rdy  [NW+2];

  // Advance a stage when it is empty or the one after it advances.
  assign rdy[NW+1] = !out_valid || !out_stall;
  generate
    for (genvar i = 0; i <= NW; i++) begin : g_rdy
      assign rdy[i] = !v[i] || rdy[i+1];
    end
  endgenerate

  assign in_stall = !rdy[0];

  qfa_front #(.FRAC_BITS(FRAC_BITS), .NW(NW)) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (rdy[0]),
    .in_valid (in_valid),
    .in_data  (in_data),
    .valid_r  (v[0]),
    .ctx_r    (ctx[0]),
    .word_r   (word[0])
  );
  // partial remainder starts at zero
  assign rem[0] = '0;

  generate
    for (genvar k = 0; k < NW; k++) begin : g_cell
      qfa_cell #(.NW(NW)) u_cell (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (rdy[k+1]),
        .in_valid (v[k]),
        .in_ctx   (ctx[k]),
        .in_rem   (rem[k]),
        .in_word  (word[k]),
        .valid_r  (v[k+1]),
        .ctx_r    (ctx[k+1]),
        .rem_r    (rem[k+1]),
        .word_r   (word[k+1])
      );
    end
  endgenerate

  qfa_finish #(.FRAC_BITS(FRAC_BITS), .NW(NW)) u_finish (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (rdy[NW+1]),
    .in_valid (v[NW]),
    .in_ctx   (ctx[NW]),
    .in_rem   (rem[NW]),
    .in_word  (word[NW]),
    .valid_r  (out_valid),
    .data_r   (out_data)
  );

endmodule

FILE: bench/q24_8_fixed_point_alu_core_tb.sv
module q24_8_fixed_point_alu_core_tb;
  import qfa_pkg::*;

  localparam int FRAC_BITS = 8;
  localparam int LATENCY   = 32 + FRAC_BITS + 2;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_stall;
  out_item_t out_data;

  // Results still owed by the ALU, oldest first.
  out_item_t pending_results[$];
  int        error_count;

  q24_8_fixed_point_alu_core #(.FRAC_BITS(FRAC_BITS)) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Saturate an exact 64-bit value to one signed word, flag overflow.
  function automatic logic [31:0] saturate_word(input logic signed [63:0] v,
                                                inout logic ovf);
    if (v > 64'sd2147483647) begin
      ovf = 1'b1;
      return WORD_MAX;
    end else if (v < -64'sd2147483648) begin
      ovf = 1'b1;
      return WORD_MIN;
    end
    return v[31:0];
  endfunction

  // Compute the result word and flags that one request must produce.
  function automatic out_item_t alu_result(input in_item_t req);
    out_item_t           r;
    logic signed [63:0]  a, b, s;
    logic        [63:0]  ma, mb, p, q, n;
    logic                neg, ovf;
    a   = 64'(req.operand_a);
    b   = 64'(req.operand_b);
    ma  = a < 0 ? -a : a;
    mb  = b < 0 ? -b : b;
    neg = (a < 0) != (b < 0);
    ovf = 1'b0;
    r   = '0;
    case (op_t'(req.req_type))
      OP_ADD: r.result_value = saturate_word(a + b, ovf);
      OP_SUB: r.result_value = saturate_word(a - b, ovf);
      OP_MUL: begin
        p = ma * mb;
        q = (p + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
        s = neg ? -$signed(q) : $signed(q);
        r.result_value = saturate_word(s, ovf);
      end
      OP_DIV: begin
        if (b == 0) begin
          r.divide_by_zero = 1'b1;
          r.result_value   = '0;
        end else begin
          n = ma << FRAC_BITS;
          q = (2 * n + mb) / (2 * mb);
          s = neg ? -$signed(q) : $signed(q);
          r.result_value = saturate_word(s, ovf);
        end
      end
      OP_INC: r.result_value = saturate_word(a + 1, ovf);
      OP_DEC: r.result_value = saturate_word(a - 1, ovf);
      OP_MIN: r.result_value = a < b ? req.operand_a : req.operand_b;
      default: r.result_value = a > b ? req.operand_a : req.operand_b;
    endcase
    r.a_less    = a < b;
    r.a_equal   = a == b;
    r.a_greater = a > b;
    r.overflow  = ovf;
    return r;
  endfunction

  // Mostly short gaps, now and then a long one.
  function automatic int gap_len();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 60) return 0;
    if (roll < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Send one item: raise valid, hold until accepted, then idle for a random gap unless no_gap is set.
  task automatic send_item(input op_t op, input logic [31:0] a,
                           input logic [31:0] b, input bit no_gap = 0);
    int idle;
    in_data  <= '{req_type: op, operand_a: a, operand_b: b};
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    pending_results.push_back(alu_result('{req_type: op, operand_a: a,
                                           operand_b: b}));
    idle = no_gap ? 0 : gap_len();
    if (idle > 0) begin
      in_valid <= 1'b0;
      repeat (idle) @(posedge clk);
    end
  endtask

  // Pick an operand biased toward edges and small magnitudes.
  function automatic logic [31:0] pick_operand();
    case ($urandom_range(0, 9))
      0: return WORD_MAX;
      1: return WORD_MIN;
      2: return 32'(int'($urandom_range(0, 4)) - 2);
      3: return 32'(int'($urandom_range(0, 8192)) - 4096);
      4: return {{16{$urandom_range(0, 1) == 1}}, 16'($urandom)};
      default: return $urandom;
    endcase
  endfunction

  task automatic test_extremes();
    logic [31:0] edges[6];
    edges = '{WORD_MAX, WORD_MIN, 32'd0, 32'd1, 32'hffff_ffff, 32'h0000_0100};
    // Every operation over pairs of edge values; compare flags on all ops.
    for (int i = 0; i < 8; i++) begin
      send_item(op_t'(i), edges[i % 6], edges[(i + 1) % 6]);
      send_item(op_t'(i), edges[(i + 3) % 6], edges[(i + 3) % 6]);
    end
    // Divide by zero and saturating corner requests.
    send_item(OP_DIV, 32'h0000_0500, 32'd0);
    send_item(OP_DIV, WORD_MIN, 32'd0);
    send_item(OP_DIV, WORD_MIN, 32'd1);
    send_item(OP_MUL, WORD_MIN, WORD_MIN);
    send_item(OP_INC, WORD_MAX, 32'd5);
    send_item(OP_DEC, WORD_MIN, 32'd5);
    // Exact halves in multiply round away from zero.
    send_item(OP_MUL, 32'd1, 32'd128);
    send_item(OP_MUL, 32'hffff_ffff, 32'd128);
  endtask

  task automatic test_back_to_back();
    // Keep valid high across a burst to fill the divider chain.
    for (int i = 0; i < 100; i++)
      send_item(op_t'($urandom_range(0, 7)), pick_operand(), pick_operand(), 1);
  endtask

  task automatic test_random_ops();
    for (int i = 0; i < 1600; i++)
      send_item(op_t'($urandom_range(0, 7)), pick_operand(), pick_operand());
  endtask

  task automatic test_drain();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
  endtask

  // Randomly stall the result side, sometimes for long stretches.
  initial begin
    int idle;
    out_stall = 1'b1;
    @(posedge rst_n);
    forever begin
      out_stall <= 1'b0;
      repeat ($urandom_range(1, 30)) @(posedge clk);
      idle = gap_len();
      if (idle > 0) begin
        out_stall <= 1'b1;
        repeat (idle) @(posedge clk);
      end
    end
  end

  // Compare each accepted result with the oldest expectation.
  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result %h", $time, out_data);
        error_count++;
      end else begin
        want = pending_results.pop_front();
        if (out_data.result_value !== want.result_value) begin
          $display("%0t: result_value expected %h actual %h", $time,
                   want.result_value, out_data.result_value);
          error_count++;
        end
        if (out_data.a_less !== want.a_less) begin
          $display("%0t: a_less expected %b actual %b", $time,
                   want.a_less, out_data.a_less);
          error_count++;
        end
        if (out_data.a_equal !== want.a_equal) begin
          $display("%0t: a_equal expected %b actual %b", $time,
                   want.a_equal, out_data.a_equal);
          error_count++;
        end
        if (out_data.a_greater !== want.a_greater) begin
          $display("%0t: a_greater expected %b actual %b", $time,
                   want.a_greater, out_data.a_greater);
          error_count++;
        end
        if (out_data.overflow !== want.overflow) begin
          $display("%0t: overflow expected %b actual %b", $time,
                   want.overflow, out_data.overflow);
          error_count++;
        end
        if (out_data.divide_by_zero !== want.divide_by_zero) begin
          $display("%0t: divide_by_zero expected %b actual %b", $time,
                   want.divide_by_zero, out_data.divide_by_zero);
          error_count++;
        end
      end
    end
  end

  initial begin
    #10000000;
    $display("FAILURE");
    $finish;
  end

  initial begin
    error_count = 0;
    rst_n    = 1'b0;
    in_valid = 1'b0;
    in_data  = '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_extremes();
    test_back_to_back();
    test_random_ops();
    test_drain();
    if (error_count == 0 && pending_results.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
